[design/pcc_pkg.sv]
// Shared types and constants for the Pearson correlation core.
// Holds field widths, multiply operation codes, and controller/datapath structs.
// Depends on nothing; compile first.
`timescale 1ns / 1ps
`default_nettype none

package pcc_pkg;

    localparam int FIELD_BITS  = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_PAIRS   = 4096;
    localparam int COUNT_BITS  = 13;
    localparam int SUM_BITS    = 28;
    localparam int SQ_BITS     = 43;
    // The cross-product sum reaches +2^42 on a full run of most-negative pairs.
    localparam int XY_BITS     = 44;
    localparam int MAG_BITS    = 56;
    localparam int PROD_BITS   = 2 * MAG_BITS;
    localparam int QUO_BITS    = 33;
    localparam int ROOT_BITS   = 17;
    localparam int COEF_BITS   = 16;
    localparam int ITER_BITS   = 6;

    // Operand pairs of the shared multiplier, in the order the controller runs them.
    typedef enum logic [2:0] {
        OP_N_SXX   = 3'd0,
        OP_SX_SX   = 3'd1,
        OP_N_SYY   = 3'd2,
        OP_SY_SY   = 3'd3,
        OP_N_SXY   = 3'd4,
        OP_SX_SY   = 3'd5,
        OP_VX_VY   = 3'd6,
        OP_COV_COV = 3'd7
    } mul_op_t;

    typedef struct packed {
        logic    accept;
        logic    mul_load;
        mul_op_t op;
        logic    store;
        logic    div_step;
        logic    sqrt_init;
        logic    sqrt_step;
        logic    out_load;
    } pcc_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic degenerate;
    } pcc_status_t;

endpackage

`default_nettype wire

[design/pcc_if.sv]
// Channel interfaces of the Pearson correlation core: sample input and result output.
// Each carries valid, ready and payload, with source and sink modports.
// Depends on pcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pcc_sample_if;
    import pcc_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [FIELD_BITS-1:0] x_sample;
    logic signed [FIELD_BITS-1:0] y_sample;
    logic                         last_sample;

    modport source (output valid, x_sample, y_sample, last_sample, input ready);
    modport sink   (input valid, x_sample, y_sample, last_sample, output ready);
endinterface

interface pcc_result_if;
    import pcc_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [COEF_BITS-1:0] coefficient;
    logic                        degenerate;

    modport source (output valid, coefficient, degenerate, input ready);
    modport sink   (input valid, coefficient, degenerate, output ready);
endinterface

`default_nettype wire

[design/pcc_datapath.sv]
// Datapath of the Pearson correlation core: running sums, shift-add multiplier,
// restoring divider, bit-serial square root and the output register.
// Depends on pcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcc_datapath
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire pcc_pkg::pcc_cmd_t                    cmd,
    output pcc_pkg::pcc_status_t                      status,
    input  wire logic signed [pcc_pkg::FIELD_BITS-1:0] x_sample,
    input  wire logic signed [pcc_pkg::FIELD_BITS-1:0] y_sample,
    output logic signed [pcc_pkg::COEF_BITS-1:0]      coefficient,
    output logic                                      degenerate
);
    import pcc_pkg::*;

    function automatic logic [MAG_BITS-1:0] magnitude(input logic signed [MAG_BITS-1:0] v);
        magnitude = v[MAG_BITS-1] ? MAG_BITS'(-v) : v;
    endfunction

    logic [COUNT_BITS-1:0]        count_reg;
    logic signed [SUM_BITS-1:0]   sum_x_reg, sum_y_reg;
    logic [SQ_BITS-1:0]           sum_xx_reg, sum_yy_reg;
    logic signed [XY_BITS-1:0]    sum_xy_reg;

    logic signed [SAMPLE_BITS-1:0]   x_val, y_val;
    logic signed [2*SAMPLE_BITS-1:0] xx_prod, yy_prod, xy_prod;

    logic [PROD_BITS-1:0]       mcand_reg, acc_reg, d_reg, rem_reg;
    logic [MAG_BITS-1:0]        mplier_reg;
    logic                       neg_mul_reg;
    logic signed [PROD_BITS-1:0] t_reg, prod, diff;
    logic signed [MAG_BITS-1:0] vx_reg, vy_reg, cov_reg;
    logic                       cov_neg_reg;
    logic signed [MAG_BITS-1:0] a_val, b_val;

    logic [QUO_BITS-1:0]      quo_reg;
    logic                     rem_ge;
    logic [PROD_BITS-1:0]     rem_sub;
    logic [ROOT_BITS-1:0]     root_reg, bit_reg, trial;
    logic [2*ROOT_BITS-1:0]   trial_sq;
    logic [ROOT_BITS:0]       q_sum;
    logic [ROOT_BITS-1:0]     q_val, q_neg;

    assign x_val   = x_sample[SAMPLE_BITS-1:0];
    assign y_val   = y_sample[SAMPLE_BITS-1:0];
    assign xx_prod = x_val * x_val;
    assign yy_prod = y_val * y_val;
    assign xy_prod = x_val * y_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
            sum_xy_reg <= '0;
        end
        else if (cmd.out_load)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
            sum_xy_reg <= '0;
        end
        else if (cmd.accept && (count_reg < COUNT_BITS'(MAX_PAIRS)))
        begin
            count_reg  <= count_reg + COUNT_BITS'(1);
            sum_x_reg  <= sum_x_reg + SUM_BITS'(x_val);
            sum_y_reg  <= sum_y_reg + SUM_BITS'(y_val);
            sum_xx_reg <= sum_xx_reg + SQ_BITS'(unsigned'(xx_prod));
            sum_yy_reg <= sum_yy_reg + SQ_BITS'(unsigned'(yy_prod));
            sum_xy_reg <= sum_xy_reg + XY_BITS'(xy_prod);
        end
    end

    always_comb
    begin
        case (cmd.op)
            OP_N_SXX:   begin a_val = MAG_BITS'(count_reg); b_val = MAG_BITS'(sum_xx_reg); end
            OP_SX_SX:   begin a_val = MAG_BITS'(sum_x_reg); b_val = MAG_BITS'(sum_x_reg); end
            OP_N_SYY:   begin a_val = MAG_BITS'(count_reg); b_val = MAG_BITS'(sum_yy_reg); end
            OP_SY_SY:   begin a_val = MAG_BITS'(sum_y_reg); b_val = MAG_BITS'(sum_y_reg); end
            OP_N_SXY:   begin a_val = MAG_BITS'(count_reg); b_val = MAG_BITS'(sum_xy_reg); end
            OP_SX_SY:   begin a_val = MAG_BITS'(sum_x_reg); b_val = MAG_BITS'(sum_y_reg); end
            OP_VX_VY:   begin a_val = vx_reg;  b_val = vy_reg;  end
            OP_COV_COV: begin a_val = cov_reg; b_val = cov_reg; end
            default:    begin a_val = '0;      b_val = '0;      end
        endcase
    end

    // Shift-add multiplier on magnitudes; finishes when the multiplier runs out of ones.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mplier_reg <= '0;
        end
        else if (cmd.mul_load)
        begin
            mplier_reg <= magnitude(b_val);
        end
        else if (mplier_reg != '0)
        begin
            mplier_reg <= mplier_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            mcand_reg   <= PROD_BITS'(magnitude(a_val));
            acc_reg     <= '0;
            neg_mul_reg <= a_val[MAG_BITS-1] ^ b_val[MAG_BITS-1];
        end
        else if (mplier_reg != '0)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg <= mcand_reg << 1;
        end
    end

    assign prod = neg_mul_reg ? -signed'(acc_reg) : signed'(acc_reg);
    assign diff = t_reg - prod;

    assign rem_ge  = (rem_reg >= d_reg);
    assign rem_sub = rem_ge ? (rem_reg - d_reg) : rem_reg;
    assign trial   = root_reg | bit_reg;
    assign trial_sq = trial * trial;

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            case (cmd.op)
                OP_SX_SX:   vx_reg <= diff[MAG_BITS-1:0];
                OP_SY_SY:   vy_reg <= diff[MAG_BITS-1:0];
                OP_SX_SY:
                begin
                    cov_reg     <= diff[MAG_BITS-1:0];
                    cov_neg_reg <= diff[PROD_BITS-1];
                end
                OP_VX_VY:   d_reg <= acc_reg;
                OP_COV_COV:
                begin
                    rem_reg <= acc_reg;
                    quo_reg <= '0;
                end
                default:    t_reg <= prod;
            endcase
        end
        if (cmd.div_step)
        begin
            rem_reg <= {rem_sub[PROD_BITS-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_BITS-2:0], rem_ge};
        end
        if (cmd.sqrt_init)
        begin
            root_reg <= '0;
            bit_reg  <= ROOT_BITS'(1) << (ROOT_BITS - 1);
        end
        else if (cmd.sqrt_step)
        begin
            if (trial_sq <= (2*ROOT_BITS)'(quo_reg))
            begin
                root_reg <= trial;
            end
            bit_reg <= bit_reg >> 1;
        end
    end

    // Largest q with 2q-1 <= root is (root+1)/2.
    assign q_sum = {1'b0, root_reg} + (ROOT_BITS+1)'(1);
    assign q_val = q_sum[ROOT_BITS:1];
    assign q_neg = ROOT_BITS'(0) - q_val;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (status.degenerate)
            begin
                coefficient <= '0;
                degenerate  <= 1'b1;
            end
            else
            begin
                degenerate <= 1'b0;
                if (cov_neg_reg)
                begin
                    coefficient <= q_neg[COEF_BITS-1:0];
                end
                else if (q_val > ROOT_BITS'(2**(COEF_BITS-1) - 1))
                begin
                    coefficient <= COEF_BITS'(2**(COEF_BITS-1) - 1);
                end
                else
                begin
                    coefficient <= q_val[COEF_BITS-1:0];
                end
            end
        end
    end

    assign status.mul_done   = (mplier_reg == '0);
    assign status.degenerate = (vx_reg == '0) || (vy_reg == '0);

endmodule

`default_nettype wire

[design/pcc_controller.sv]
// Controller of the Pearson correlation core: sequences accumulation, the
// multiply program, division, square root and result hand-off.
// Depends on pcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcc_controller
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_last,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire pcc_pkg::pcc_status_t status,
    output pcc_pkg::pcc_cmd_t         cmd
);
    import pcc_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_LOAD      = 8'b0000_0010,
        S_MUL       = 8'b0000_0100,
        S_CHECK     = 8'b0000_1000,
        S_DIV       = 8'b0001_0000,
        S_SQRT_INIT = 8'b0010_0000,
        S_SQRT      = 8'b0100_0000,
        S_OUT       = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    mul_op_t               op_reg, op_next;
    logic [ITER_BITS-1:0]  iter_reg, iter_next;
    logic                  out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_N_SXX;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.op         = op_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (in_last)
                    begin
                        op_next    = OP_N_SXX;
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                if (status.mul_done)
                begin
                    cmd.store = 1'b1;
                    case (op_reg)
                        OP_SY_SY:   state_next = S_CHECK;
                        OP_COV_COV:
                        begin
                            iter_next  = '0;
                            state_next = S_DIV;
                        end
                        default:
                        begin
                            op_next    = mul_op_t'(op_reg + 3'd1);
                            state_next = S_LOAD;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                if (status.degenerate)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    op_next    = OP_N_SXY;
                    state_next = S_LOAD;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg + ITER_BITS'(1);
                if (iter_reg == ITER_BITS'(QUO_BITS - 1))
                begin
                    state_next = S_SQRT_INIT;
                end
            end
            S_SQRT_INIT:
            begin
                cmd.sqrt_init = 1'b1;
                iter_next     = '0;
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                iter_next     = iter_reg + ITER_BITS'(1);
                if (iter_reg == ITER_BITS'(ROOT_BITS - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/pearson_correlation_core.sv]
// Top level of the Pearson correlation core.
// Joins pcc_controller and pcc_datapath; depends on pcc_pkg and the pcc_if interfaces.
//
//  Channel   Direction  Transaction payload
//  in_ch     sink       x_sample, y_sample (signed 16), last_sample
//  out_ch    source     coefficient (signed Q1.15), degenerate
//
// Pairs are accumulated one per cycle while the core is idle.
// After a transaction marked last, the core runs up to eight multiplications on one
// shift-add multiplier, a restoring divide and a bit-serial square root before the
// result is registered; a degenerate run goes to hand-off after the fourth multiplication.
// Reset clears the count, the sums and all control state.
// A result waiting on out_ch does not block accumulation of the next run; only the
// hand-off of the following result waits for it to be taken.
`timescale 1ns / 1ps
`default_nettype none

module pearson_correlation_core
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    pcc_sample_if.sink   in_ch,
    pcc_result_if.source out_ch
);
    import pcc_pkg::*;

    pcc_cmd_t    cmd;
    pcc_status_t status;

    // The controller owns all sequencing and the output valid flag.
    pcc_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_last   (in_ch.last_sample),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the sums, the arithmetic units and the result register.
    pcc_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .x_sample    (in_ch.x_sample),
        .y_sample    (in_ch.y_sample),
        .coefficient (out_ch.coefficient),
        .degenerate  (out_ch.degenerate)
    );

    // A degenerate result always carries a zero coefficient.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.degenerate) |-> (out_ch.coefficient == '0))
        else $error("degenerate result with nonzero coefficient");

    // Loading the result register presents a result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_ch.valid)
        else $error("result loaded but not presented");

    // No sample is taken while the divider is stepping.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !in_ch.ready)
        else $error("input ready during division");

endmodule

`default_nettype wire

[verif/tb_pcc_channels.sv]
// Testbench-side view of the Pearson correlation core channels.
// The interfaces themselves come from design/pcc_if.sv; this file holds shared helpers.
// Depends on pcc_pkg.
`timescale 1ns / 1ps

package tb_pcc_util;
    import pcc_pkg::*;

    // Expected result of one run.
    typedef struct {
        logic signed [COEF_BITS-1:0] coefficient;
        logic                        degenerate;
    } corr_result_t;
endpackage

[verif/tb_top.sv]
// Self-checking testbench for pearson_correlation_core.
// Drives sample runs, predicts each run's Q1.15 correlation exactly and checks results.
// Depends on pcc_pkg, the pcc_if interfaces and tb_pcc_util.
`timescale 1ns / 1ps

module tb_top;
    import pcc_pkg::*;
    import tb_pcc_util::*;

    logic clk;
    logic rst_n;
    pcc_sample_if in_ch ();
    pcc_result_if out_ch ();

    pearson_correlation_core dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

    // Running state of the predictor, mirroring the core's accumulators.
    int unsigned     run_pairs;
    longint signed   acc_x, acc_y, acc_xy;
    longint signed   acc_xx, acc_yy;
    corr_result_t    expected_results[$];

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  failed;
    longint cycle_count;
    localparam longint CYCLE_LIMIT = 3_000_000;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("pearson_correlation_core: mismatch");
                $finish;
            end
        end
    end

    // Exact correlation rounding: largest q in [0,32768] such that
    // (2q-1)^2 * vx * vy <= (65536 * |cov|)^2.
    function automatic corr_result_t correlate_run();
        corr_result_t r;
        logic signed [255:0] n, vx, vy, cov, d, a2, t;
        int unsigned lo, hi, mid;
        bit neg;
        n   = run_pairs;
        vx  = n * 256'(acc_xx) - 256'(acc_x) * 256'(acc_x);
        vy  = n * 256'(acc_yy) - 256'(acc_y) * 256'(acc_y);
        if (vx == 0 || vy == 0)
        begin
            r.coefficient = '0;
            r.degenerate  = 1'b1;
            return r;
        end
        cov = n * 256'(acc_xy) - 256'(acc_x) * 256'(acc_y);
        neg = cov < 0;
        if (neg)
            cov = -cov;
        d  = vx * vy;
        a2 = (cov * 65536) * (cov * 65536);
        lo = 0;
        hi = 32768;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            t = 256'(2 * mid - 1);
            t = t * t * d;
            if (t <= a2)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (!neg)
            r.coefficient = (lo > 32767) ? 16'sd32767 : 16'(lo);
        else
            r.coefficient = 16'(65536 - lo);
        r.degenerate = 1'b0;
        return r;
    endfunction

    // Update the predictor with one accepted pair; a last pair closes the run.
    task automatic predict_pair(input logic signed [15:0] xs, input logic signed [15:0] ys,
                                input logic last);
        longint signed x, y;
        x = xs;
        y = ys;
        if (run_pairs < MAX_PAIRS)
        begin
            run_pairs++;
            acc_x  += x;
            acc_y  += y;
            acc_xx += x * x;
            acc_yy += y * y;
            acc_xy += x * y;
        end
        if (last)
        begin
            expected_results.insert(expected_results.size(), correlate_run());
            run_pairs = 0;
            acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
        end
    endtask

    // Send one pair and wait for its transaction to complete; valid stays high
    // afterwards until the next idle cycle or the end of the stimulus.
    task automatic send_pair(input logic signed [15:0] xs, input logic signed [15:0] ys,
                             input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.x_sample    <= xs;
        in_ch.y_sample    <= ys;
        in_ch.last_sample <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_pair(xs, ys, last);
    endtask

    // Receiver: random stalls, each result transaction is compared with the oldest expectation.
    initial
    begin
        corr_result_t exp_r;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result coef=%0d degenerate=%0b", $time,
                             out_ch.coefficient, out_ch.degenerate);
                    failed = 1'b1;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (out_ch.coefficient !== exp_r.coefficient)
                    begin
                        $display("%0t: coefficient expected %0d actual %0d", $time,
                                 exp_r.coefficient, out_ch.coefficient);
                        failed = 1'b1;
                    end
                    if (out_ch.degenerate !== exp_r.degenerate)
                    begin
                        $display("%0t: degenerate expected %0b actual %0b", $time,
                                 exp_r.degenerate, out_ch.degenerate);
                        failed = 1'b1;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'($urandom_range(7)) - 16'sd3;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    // Extremes, a one-pair run, constant series, perfect and inverse correlation.
    task automatic test_directed();
        send_pair(16'sd5, 16'sd9, 1'b1);
        send_pair(16'sd3, 16'sd1, 1'b0);
        send_pair(16'sd3, 16'sd7, 1'b1);
        send_pair(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_pair(16'sh8000, 16'sh8000, 1'b1);
        send_pair(16'sh7FFF, 16'sh8000, 1'b0);
        send_pair(16'sh8000, 16'sh7FFF, 1'b1);
        send_pair(-16'sd1, 16'sd2, 1'b0);
        send_pair(16'sd0, -16'sd5, 1'b0);
        send_pair(16'sd4, 16'sd1, 1'b0);
        send_pair(16'shFFFF, 16'sh5555, 1'b1);
        send_pair(16'sd1, 16'sd1, 1'b0);
        send_pair(16'sd2, 16'sd3, 1'b0);
        send_pair(16'sd3, 16'sd2, 1'b1);
    endtask

    // Random runs, mostly short, with random content.
    task automatic test_random_runs(input int pairs);
        int left, len;
        left = pairs;
        while (left > 0)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 2) : $urandom_range(8, 1);
            for (int i = 0; i < len && left > 0; i++)
            begin
                left--;
                send_pair(rand_sample(), rand_sample(), (i == len - 1) || left == 0);
            end
        end
    endtask

    initial
    begin
        failed = 1'b0;
        run_pairs = 0;
        acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        in_ch.valid       <= 1'b0;
        in_ch.x_sample    <= '0;
        in_ch.y_sample    <= '0;
        in_ch.last_sample <= 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_runs(200);
        send_idle_pct = 74;
        test_random_runs(200);
        send_idle_pct = 0;
        recv_stall_pct = 74;
        test_random_runs(200);
        send_idle_pct = 36;
        recv_stall_pct = 36;
        test_random_runs(200);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        in_ch.valid <= 1'b0;

        wait_drained();
        if (!failed)
            $display("pearson_correlation_core: match");
        else
            $display("pearson_correlation_core: mismatch");
        $finish;
    end

endmodule
